// ===== rtl/cohp_pkg.sv =====
package cohp_pkg;

    // Fixed field widths
    localparam int SAMPLE_W   = 16;
    localparam int STATE_W    = 20;
    localparam int DIFF_W     = STATE_W + 1;
    localparam int B0_W       = 19;
    localparam int G_W        = 18;
    localparam int CNT_W      = 3;
    localparam int FRAC_BITS  = 18;
    localparam int FF_PROD_W  = B0_W + 1 + DIFF_W;
    localparam int FB_PROD_W  = G_W + 1 + STATE_W;
    localparam int SUM_W      = FF_PROD_W + 2;
    localparam int RND_W      = SUM_W - FRAC_BITS;

    // Stage index compare width, covers up to 32 built stages
    localparam int IDX_W      = 5;

    // Configuration port
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] REG_RUN_ENABLE    = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_B0_COEF       = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] REG_G_COEF        = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] REG_STAGES_IN_USE = CFG_IDX_W'(3);

    localparam logic             RUN_RESET    = 1'b1;
    localparam logic [B0_W-1:0]  B0_RESET     = B0_W'(262144);
    localparam logic [G_W-1:0]   G_RESET      = '0;
    localparam logic [CNT_W-1:0] STAGES_RESET = CNT_W'(2);

    localparam int NUM_STAGES_DEFAULT = 4;

    typedef struct packed {
        logic             run_enable;
        logic [B0_W-1:0]  b0_coef;
        logic [G_W-1:0]   g_coef;
        logic [CNT_W-1:0] stages_in_use;
    } cfg_t;

    // One beat moving between neighboring cells
    typedef struct packed {
        logic                      valid;
        logic                      clear;
        logic signed [STATE_W-1:0] x;
    } link_t;

    // Round half up after the Q24.18 product sum, then clamp to 20 bits
    function automatic logic signed [STATE_W-1:0] round_sat20(
        input logic signed [SUM_W-1:0] sum
    );
        logic signed [SUM_W-1:0] biased;
        logic signed [RND_W-1:0] r;
        logic signed [RND_W-1:0] hi;
        logic signed [RND_W-1:0] lo;
        biased = sum + SUM_W'(1 << (FRAC_BITS - 1));
        r      = biased[SUM_W-1:FRAC_BITS];
        hi     = RND_W'((1 << (STATE_W - 1)) - 1);
        lo     = -RND_W'(1 << (STATE_W - 1));
        if (r > hi)
            return hi[STATE_W-1:0];
        else if (r < lo)
            return lo[STATE_W-1:0];
        else
            return r[STATE_W-1:0];
    endfunction

    function automatic logic signed [SAMPLE_W-1:0] sat16(
        input logic signed [STATE_W-1:0] v
    );
        logic signed [STATE_W-1:0] hi;
        logic signed [STATE_W-1:0] lo;
        hi = STATE_W'((1 << (SAMPLE_W - 1)) - 1);
        lo = -STATE_W'(1 << (SAMPLE_W - 1));
        if (v > hi)
            return hi[SAMPLE_W-1:0];
        else if (v < lo)
            return lo[SAMPLE_W-1:0];
        else
            return v[SAMPLE_W-1:0];
    endfunction

endpackage

// ===== rtl/cohp_in_if.sv =====
interface cohp_in_if;
    logic                                 valid;
    logic                                 ready;
    logic signed [cohp_pkg::SAMPLE_W-1:0] sample_in;
    logic                                 clear_history;

    modport source (output valid, output sample_in, output clear_history, input ready);
    modport sink   (input valid, input sample_in, input clear_history, output ready);
endinterface

// ===== rtl/cohp_out_if.sv =====
interface cohp_out_if;
    logic                                 valid;
    logic                                 ready;
    logic signed [cohp_pkg::SAMPLE_W-1:0] sample_out;

    modport source (output valid, output sample_out, input ready);
    modport sink   (input valid, input sample_out, output ready);
endinterface

// ===== rtl/cohp_cfg_if.sv =====
interface cohp_cfg_if;
    logic                                   valid;
    logic                                   ready;
    logic [cohp_pkg::CFG_IDX_W-1:0]         index;
    logic [cohp_pkg::CFG_DATA_W-1:0]        data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== rtl/cohp_cell.sv =====
module cohp_cell #(
    parameter int IDX = 0
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 advance,
    input  cohp_pkg::cfg_t       cfg,
    input  cohp_pkg::link_t      up,
    output cohp_pkg::link_t      down
);

    localparam logic [cohp_pkg::IDX_W-1:0] MY_IDX = cohp_pkg::IDX_W'(IDX);

    // Cell takes part when filtering and within the clamped stage count
    logic [cohp_pkg::IDX_W-1:0] eff_count;
    logic                       active;

    always_comb
    begin
        eff_count = (cfg.stages_in_use == '0) ? cohp_pkg::IDX_W'(1)
                                              : cohp_pkg::IDX_W'(cfg.stages_in_use);
        active    = cfg.run_enable && (MY_IDX < eff_count);
    end

    // ---- Level A: feedforward product ----
    logic                                   a_valid_reg, a_valid_next;
    logic                                   a_clear_reg;
    logic signed [cohp_pkg::STATE_W-1:0]    a_x_reg;
    logic signed [cohp_pkg::FF_PROD_W-1:0]  a_prod_reg, a_prod_next;
    logic signed [cohp_pkg::STATE_W-1:0]    xprev_reg, xprev_next;
    logic signed [cohp_pkg::STATE_W-1:0]    xprev_use;
    logic signed [cohp_pkg::DIFF_W-1:0]     diff;

    // Cells past the stage count still drop their history on a clear while run_enable is high
    always_comb
    begin
        xprev_use    = up.clear ? '0 : xprev_reg;
        diff         = cohp_pkg::DIFF_W'(up.x) - cohp_pkg::DIFF_W'(xprev_use);
        a_prod_next  = $signed({1'b0, cfg.b0_coef}) * diff;
        a_valid_next = advance ? up.valid : a_valid_reg;
        xprev_next   = (advance && up.valid && active) ? up.x :
                       (advance && up.valid && cfg.run_enable && up.clear) ? '0 : xprev_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            xprev_reg   <= '0;
        end
        else
        begin
            a_valid_reg <= a_valid_next;
            xprev_reg   <= xprev_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            a_clear_reg <= up.clear;
            a_x_reg     <= up.x;
            a_prod_reg  <= a_prod_next;
        end
    end

    // ---- Level B: feedback product, sum, round, clamp ----
    logic                                   b_valid_reg, b_valid_next;
    logic                                   b_clear_reg;
    logic signed [cohp_pkg::STATE_W-1:0]    b_x_reg, b_x_next;
    logic signed [cohp_pkg::STATE_W-1:0]    yprev_reg, yprev_next;
    logic signed [cohp_pkg::STATE_W-1:0]    yprev_use;
    logic signed [cohp_pkg::FB_PROD_W-1:0]  fb_prod;
    logic signed [cohp_pkg::SUM_W-1:0]      sum;
    logic signed [cohp_pkg::STATE_W-1:0]    y;

    always_comb
    begin
        yprev_use    = a_clear_reg ? '0 : yprev_reg;
        fb_prod      = $signed({1'b0, cfg.g_coef}) * yprev_use;
        sum          = cohp_pkg::SUM_W'(a_prod_reg) + cohp_pkg::SUM_W'(fb_prod);
        y            = cohp_pkg::round_sat20(sum);
        b_x_next     = active ? y : a_x_reg;
        b_valid_next = advance ? a_valid_reg : b_valid_reg;
        yprev_next   = (advance && a_valid_reg && active) ? y :
                       (advance && a_valid_reg && cfg.run_enable && a_clear_reg) ? '0 :
                       yprev_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_valid_reg <= 1'b0;
            yprev_reg   <= '0;
        end
        else
        begin
            b_valid_reg <= b_valid_next;
            yprev_reg   <= yprev_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            b_clear_reg <= a_clear_reg;
            b_x_reg     <= b_x_next;
        end
    end

    assign down.valid = b_valid_reg;
    assign down.clear = b_clear_reg;
    assign down.x     = b_x_reg;

endmodule

// ===== rtl/cascaded_one_pole_highpass.sv =====
// Cascaded one-pole high-pass filter.
//
// din  : input beats, signed 16-bit sample_in plus clear_history, which zeroes
//        every stage's history before that sample is filtered.
// dout : output beats, signed 16-bit sample_out, one per input beat, in order.
// cfg  : register writes (index 0 run_enable, 1 b0_coef, 2 g_coef,
//        3 stages_in_use); always ready, write only while the filter is idle.
//
// Each stage cell is two register levels deep (feedforward product, then
// feedback product with sum, rounding and clamp), and an output register
// follows the last cell. One beat is taken per cycle while dout does not
// stall; a stage's feedback closes within its second level.
// With run_enable low samples ride through the chain unchanged and no
// history is touched; cells past stages_in_use pass data through too.
// Reset zeroes all stage history, empties the chain and loads the register
// defaults. When dout stalls the whole chain holds, and din.ready drops
// until the output beat is taken.
module cascaded_one_pole_highpass #(
    parameter int NUM_STAGES = cohp_pkg::NUM_STAGES_DEFAULT
) (
    input  logic        clk,
    input  logic        rst_n,
    cohp_in_if.sink     din,
    cohp_out_if.source  dout,
    cohp_cfg_if.sink    cfg
);

    // Configuration registers
    cohp_pkg::cfg_t cfg_reg, cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg.valid)
        begin
            unique case (cfg.index)
                cohp_pkg::REG_RUN_ENABLE:
                    cfg_next.run_enable = cfg.data[0];
                cohp_pkg::REG_B0_COEF:
                    cfg_next.b0_coef = cfg.data[cohp_pkg::B0_W-1:0];
                cohp_pkg::REG_G_COEF:
                    cfg_next.g_coef = cfg.data[cohp_pkg::G_W-1:0];
                cohp_pkg::REG_STAGES_IN_USE:
                    cfg_next.stages_in_use = cfg.data[cohp_pkg::CNT_W-1:0];
                default:
                    cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.run_enable    <= cohp_pkg::RUN_RESET;
            cfg_reg.b0_coef       <= cohp_pkg::B0_RESET;
            cfg_reg.g_coef        <= cohp_pkg::G_RESET;
            cfg_reg.stages_in_use <= cohp_pkg::STAGES_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg.ready = 1'b1;

    // Chain moves whenever the output slot is free or being emptied
    logic out_valid_reg, out_valid_next;
    logic advance;

    assign advance   = !out_valid_reg || dout.ready;
    assign din.ready = advance;

    // Cell chain
    cohp_pkg::link_t link [NUM_STAGES+1];

    assign link[0].valid = din.valid;
    assign link[0].clear = din.clear_history;
    assign link[0].x     = cohp_pkg::STATE_W'(din.sample_in);

    for (genvar i = 0; i < NUM_STAGES; i++)
    begin : g_cell
        cohp_cell #(
            .IDX (i)
        ) u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .advance (advance),
            .cfg     (cfg_reg),
            .up      (link[i]),
            .down    (link[i+1])
        );
    end

    // Output register
    logic signed [cohp_pkg::SAMPLE_W-1:0] out_sample_reg;

    assign out_valid_next = advance ? link[NUM_STAGES].valid : out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
            out_sample_reg <= cohp_pkg::sat16(link[NUM_STAGES].x);
    end

    assign dout.valid      = out_valid_reg;
    assign dout.sample_out = out_sample_reg;

endmodule

// ===== rtl/cohp_checker.sv =====
module cohp_checker (
    input logic                                 clk,
    input logic                                 rst_n,
    input logic                                 in_valid,
    input logic                                 in_ready,
    input logic                                 out_valid,
    input logic                                 out_ready,
    input logic signed [cohp_pkg::SAMPLE_W-1:0] out_sample,
    input logic                                 cfg_ready
);

    // A stalled output beat holds its value
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_sample))
        else $error("output beat changed while stalled");

    // An empty output slot never blocks the input
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input blocked with empty output slot");

    // No beat taken while the output is blocked, or one would be lost
    a_no_take_blocked: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |-> !(in_valid && in_ready))
        else $error("input beat taken while output blocked");

    // Register writes are never refused
    a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_ready)
        else $error("configuration port not ready");

endmodule

bind cascaded_one_pole_highpass cohp_checker u_cohp_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (din.valid),
    .in_ready   (din.ready),
    .out_valid  (dout.valid),
    .out_ready  (dout.ready),
    .out_sample (dout.sample_out),
    .cfg_ready  (cfg.ready)
);
